@@ sv/wrp_pkg.sv @@
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the RIFF/WAVE header parser: tag words,
// parse stages, chunk kinds, status codes and the queued result record.
// ----------------------------------------------------------------------------
package wrp_pkg;

    // Little-endian tag words as they build up in the header register
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Parse stages
    localparam logic [1:0] STG_RIFF = 2'd0;
    localparam logic [1:0] STG_WAVE = 2'd1;
    localparam logic [1:0] STG_HDR  = 2'd2;
    localparam logic [1:0] STG_BODY = 2'd3;

    // Kind of chunk body being skipped
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_FMT   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // Result status codes; the error latch uses the same codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_NOT_PCM  = 3'd4;

    // PCM format tag
    localparam logic [15:0] FMT_PCM = 16'd1;

    // Format field byte offsets inside the fmt body
    localparam logic [4:0] FIDX_END = 5'd16;

    // Result queue between parser and arithmetic back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Parsed record, one per file
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_offset;
        logic [31:0] data_length;
    } t_wrp_rec;

endpackage

@@ sv/wav_riff_header_parser_core.sv @@
// Flow: the end-of-file beat writes the record into the queue; the back end loads it,
//   runs two multiply steps and holds the result on the output ports until popped.
// Throughput: one file byte per cycle while full is low; the two-step multiply back end
//   loads no record until the held result is popped, and a 2-deep record queue absorbs bursts.
// full is high while the record queue holds two records, and then stalls every byte.
// Reset (synchronous, active low) clears the parser, empties the queue, idles the back end.
// ----------------------------------------------------------------------------
// wav_riff_header_parser_core
// RIFF/WAVE header parser: byte parser front end, record queue and an
// arithmetic back end that derives block align and byte rate.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_sample_bits,
    output logic [15:0] o_block_align,
    output logic [31:0] o_bytes_per_second,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_length
);

    logic              w_accept;
    logic              w_rec_push;
    wrp_pkg::t_wrp_rec w_front_rec;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_q_pop;
    wrp_pkg::t_wrp_rec w_q_rec;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // Parse bytes
    wrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_rec_push    (w_rec_push),
        .o_rec         (w_front_rec)
    );

    // Hold parsed records
    wrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_rec   (w_front_rec),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_rec   (w_q_rec)
    );

    // Derive and deliver results
    wrp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (w_q_empty),
        .i_q_rec            (w_q_rec),
        .o_q_pop            (w_q_pop),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_status           (o_status),
        .o_channel_count    (o_channel_count),
        .o_sample_rate      (o_sample_rate),
        .o_sample_bits      (o_sample_bits),
        .o_block_align      (o_block_align),
        .o_bytes_per_second (o_bytes_per_second),
        .o_data_offset      (o_data_offset),
        .o_data_length      (o_data_length)
    );

endmodule

@@ sv/wrp_front.sv @@
// ----------------------------------------------------------------------------
// wrp_front
// Byte parser. Checks the RIFF and WAVE tags, walks chunk headers, skips
// bodies, captures fmt and data fields and forms one record at end of file.
// ----------------------------------------------------------------------------
module wrp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_file,
    output logic              o_rec_push,
    output wrp_pkg::t_wrp_rec o_rec
);

    logic [31:0] r_pos,   n_pos;
    logic [1:0]  r_stage, n_stage;
    logic [63:0] r_shift, n_shift;
    logic [2:0]  r_fill,  n_fill;
    logic [31:0] r_rem,   n_rem;
    logic [1:0]  r_kind,  n_kind;
    logic [4:0]  r_fidx,  n_fidx;
    logic [15:0] r_tag,   n_tag;
    logic [15:0] r_ch,    n_ch;
    logic [31:0] r_rate,  n_rate;
    logic [15:0] r_bits,  n_bits;
    logic [31:0] r_dstart, n_dstart;
    logic [31:0] r_dsize, n_dsize;
    logic        r_fmt_found,  n_fmt_found;
    logic        r_data_found, n_data_found;
    logic [2:0]  r_err,   n_err;

    logic [3:0]  w_cnt;
    logic [2:0]  w_status;
    logic [63:0] w_hdr;
    logic [31:0] w_id;
    logic [31:0] w_size;

    // Place the byte on the inputs into the header word
    always_comb begin
        w_hdr = r_shift;
        w_hdr[{r_fill, 3'b000} +: 8] = i_data_byte;
    end

    assign w_id   = w_hdr[31:0];
    assign w_size = w_hdr[63:32];

    // Work out the next parse state for the byte on the inputs
    always_comb begin
        n_pos        = r_pos + 32'd1;
        n_stage      = r_stage;
        n_shift      = r_shift;
        n_fill       = r_fill;
        n_rem        = r_rem;
        n_kind       = r_kind;
        n_fidx       = r_fidx;
        n_tag        = r_tag;
        n_ch         = r_ch;
        n_rate       = r_rate;
        n_bits       = r_bits;
        n_dstart     = r_dstart;
        n_dsize      = r_dsize;
        n_fmt_found  = r_fmt_found;
        n_data_found = r_data_found;
        n_err        = r_err;
        w_cnt        = {1'b0, r_fill} + 4'd1;

        if (r_err == wrp_pkg::ST_OK) begin
            if (r_stage == wrp_pkg::STG_BODY) begin
                // Pick format fields out of an fmt body
                if (r_kind == wrp_pkg::KIND_FMT) begin
                    case (r_fidx) inside
                        5'd0, 5'd1: n_tag[{r_fidx[0], 3'b000} +: 8] = i_data_byte;
                        5'd2, 5'd3: n_ch[{r_fidx[0], 3'b000} +: 8] = i_data_byte;
                        [5'd4:5'd7]: n_rate[{r_fidx[1:0], 3'b000} +: 8] = i_data_byte;
                        5'd14, 5'd15: n_bits[{r_fidx[0], 3'b000} +: 8] = i_data_byte;
                        default: ;
                    endcase
                    if (r_fidx < wrp_pkg::FIDX_END) begin
                        n_fidx = r_fidx + 5'd1;
                    end
                end
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) begin
                    n_stage = wrp_pkg::STG_HDR;
                end
            end else begin
                // Gather header bytes
                n_shift = w_hdr;
                n_fill  = w_cnt[2:0];
                unique case (r_stage)
                    wrp_pkg::STG_RIFF: begin
                        if (w_cnt == 4'd4 && w_id != wrp_pkg::TAG_RIFF) begin
                            n_err = wrp_pkg::ST_NOT_RIFF;
                        end else if (w_cnt == 4'd8) begin
                            n_stage = wrp_pkg::STG_WAVE;
                            n_fill  = 3'd0;
                            n_shift = 64'd0;
                        end
                    end
                    wrp_pkg::STG_WAVE: begin
                        if (w_cnt == 4'd4) begin
                            if (w_id != wrp_pkg::TAG_WAVE) begin
                                n_err = wrp_pkg::ST_NOT_WAVE;
                            end else begin
                                n_stage = wrp_pkg::STG_HDR;
                            end
                            n_fill  = 3'd0;
                            n_shift = 64'd0;
                        end
                    end
                    wrp_pkg::STG_HDR: begin
                        if (w_cnt == 4'd8) begin
                            n_kind = wrp_pkg::KIND_OTHER;
                            if (w_id == wrp_pkg::TAG_FMT) begin
                                n_kind      = wrp_pkg::KIND_FMT;
                                n_fmt_found = 1'b1;
                                n_fidx      = 5'd0;
                                n_tag       = 16'd0;
                                n_ch        = 16'd0;
                                n_rate      = 32'd0;
                                n_bits      = 16'd0;
                            end else if (w_id == wrp_pkg::TAG_DATA) begin
                                n_kind       = wrp_pkg::KIND_DATA;
                                n_data_found = 1'b1;
                                n_dstart     = n_pos;
                                n_dsize      = w_size;
                            end
                            n_rem   = w_size;
                            n_stage = (w_size != 32'd0) ? wrp_pkg::STG_BODY
                                                        : wrp_pkg::STG_HDR;
                            n_fill  = 3'd0;
                            n_shift = 64'd0;
                        end
                    end
                    wrp_pkg::STG_BODY: ;
                    default: ;
                endcase
            end
        end
    end

    // Classify the file once the final byte is parsed
    always_comb begin
        if (n_err != wrp_pkg::ST_OK) begin
            w_status = n_err;
        end else if (n_stage == wrp_pkg::STG_RIFF) begin
            w_status = (n_fill < 3'd4) ? wrp_pkg::ST_NOT_RIFF : wrp_pkg::ST_NOT_WAVE;
        end else if (n_stage == wrp_pkg::STG_WAVE) begin
            w_status = wrp_pkg::ST_NOT_WAVE;
        end else if (!n_fmt_found || !n_data_found) begin
            w_status = wrp_pkg::ST_MISSING;
        end else if (n_tag != wrp_pkg::FMT_PCM) begin
            w_status = wrp_pkg::ST_NOT_PCM;
        end else begin
            w_status = wrp_pkg::ST_OK;
        end
    end

    // Form the record; zero the fields unless the file parsed clean
    always_comb begin
        o_rec        = '0;
        o_rec.status = w_status;
        if (w_status == wrp_pkg::ST_OK) begin
            o_rec.channel_count = n_ch;
            o_rec.sample_rate   = n_rate;
            o_rec.sample_bits   = n_bits;
            o_rec.data_offset   = n_dstart;
            o_rec.data_length   = n_dsize;
        end
    end

    assign o_rec_push = i_accept && i_end_of_file;

    // Advance on each accepted beat; return to reset after end of file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_file)) begin
            r_pos        <= 32'd0;
            r_stage      <= wrp_pkg::STG_RIFF;
            r_shift      <= 64'd0;
            r_fill       <= 3'd0;
            r_rem        <= 32'd0;
            r_kind       <= wrp_pkg::KIND_OTHER;
            r_fidx       <= 5'd0;
            r_tag        <= 16'd0;
            r_ch         <= 16'd0;
            r_rate       <= 32'd0;
            r_bits       <= 16'd0;
            r_dstart     <= 32'd0;
            r_dsize      <= 32'd0;
            r_fmt_found  <= 1'b0;
            r_data_found <= 1'b0;
            r_err        <= wrp_pkg::ST_OK;
        end else if (i_accept) begin
            r_pos        <= n_pos;
            r_stage      <= n_stage;
            r_shift      <= n_shift;
            r_fill       <= n_fill;
            r_rem        <= n_rem;
            r_kind       <= n_kind;
            r_fidx       <= n_fidx;
            r_tag        <= n_tag;
            r_ch         <= n_ch;
            r_rate       <= n_rate;
            r_bits       <= n_bits;
            r_dstart     <= n_dstart;
            r_dsize      <= n_dsize;
            r_fmt_found  <= n_fmt_found;
            r_data_found <= n_data_found;
            r_err        <= n_err;
        end
    end

endmodule

@@ sv/wrp_queue.sv @@
// ----------------------------------------------------------------------------
// wrp_queue
// Short record queue that decouples the byte parser from the arithmetic
// back end.
// ----------------------------------------------------------------------------
module wrp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wrp_pkg::t_wrp_rec i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output wrp_pkg::t_wrp_rec o_rec
);

    localparam int AW = wrp_pkg::QUEUE_AW;

    wrp_pkg::t_wrp_rec r_mem [wrp_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW-1:0]     r_rptr, n_rptr;
    logic [AW:0]       r_count, n_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == (AW+1)'(wrp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Step pointers and fill level
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == AW'(wrp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (w_rd) begin
            n_rptr = (r_rptr == AW'(wrp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + (AW+1)'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the incoming record
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

@@ sv/wrp_back.sv @@
// ----------------------------------------------------------------------------
// wrp_back
// Arithmetic back end. Takes one record, derives block align and byte rate
// over two multiply steps and holds the finished result for the consumer.
// ----------------------------------------------------------------------------
module wrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  wrp_pkg::t_wrp_rec i_q_rec,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [2:0]        o_status,
    output logic [15:0]       o_channel_count,
    output logic [31:0]       o_sample_rate,
    output logic [15:0]       o_sample_bits,
    output logic [15:0]       o_block_align,
    output logic [31:0]       o_bytes_per_second,
    output logic [31:0]       o_data_offset,
    output logic [31:0]       o_data_length
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    wrp_pkg::t_wrp_rec r_rec;
    logic [31:0]       r_prod1;
    logic [15:0]       r_align;
    logic [31:0]       r_bps;
    logic [15:0]       w_align;
    logic [47:0]       w_prod2;

    assign w_align = r_prod1[18:3];
    assign w_prod2 = 48'(r_rec.sample_rate) * 48'(w_align);
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty = (r_state != S_DONE);

    // Sequence load, two multiplies, then hold until taken
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_q_empty) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DONE;
            S_DONE: if (i_pop) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_rec;
        end
        if (r_state == S_MUL1) begin
            r_prod1 <= 32'(r_rec.channel_count) * 32'(r_rec.sample_bits);
        end
        if (r_state == S_MUL2) begin
            r_align <= w_align;
            r_bps   <= w_prod2[31:0];
        end
    end

    assign o_status           = r_rec.status;
    assign o_channel_count    = r_rec.channel_count;
    assign o_sample_rate      = r_rec.sample_rate;
    assign o_sample_bits      = r_rec.sample_bits;
    assign o_block_align      = r_align;
    assign o_bytes_per_second = r_bps;
    assign o_data_offset      = r_rec.data_offset;
    assign o_data_length      = r_rec.data_length;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RIFF/WAVE header parser. Whole files are fed
// byte by byte through the input queue port. A bit-true predictor parses the
// same bytes and queues one expected record per file. Each popped record is
// compared field by field. Short directed files come first, then random files:
// mostly well formed with random chunks, the rest broken tags and noise.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FILE_BYTE_TARGET = 1925;
    localparam int RUN_LIMIT        = 3_000_000;
    localparam int DRAIN_CYCLES     = 12;

    typedef struct {
        logic [7:0] data;
        logic       eof;
        logic       hold;
    } t_file_beat;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [15:0] block_align;
        logic [31:0] bytes_per_second;
        logic [31:0] data_offset;
        logic [31:0] data_length;
    } t_wav_summary;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        pop           = 1'b0;
    logic [7:0]  i_data_byte   = 8'd0;
    logic        i_end_of_file = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  o_status;
    logic [15:0] o_channel_count;
    logic [31:0] o_sample_rate;
    logic [15:0] o_sample_bits;
    logic [15:0] o_block_align;
    logic [31:0] o_bytes_per_second;
    logic [31:0] o_data_offset;
    logic [31:0] o_data_length;

    // Stimulus and expectation stores
    t_file_beat   file_beats[$];
    logic [7:0]   file_bytes[$];
    t_wav_summary summaries[$];
    int           err_count = 0;
    int           in_beats  = 0;
    int           out_beats = 0;

    // Predictor state
    logic [31:0] pos_count;
    logic [1:0]  stage;
    logic [63:0] hdr_word;
    logic [2:0]  hdr_count;
    logic [31:0] body_left;
    logic [1:0]  body_type;
    logic [4:0]  fmt_ofs;
    logic [15:0] fmt_tag;
    logic [15:0] chan;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] data_at;
    logic [31:0] data_len;
    logic        have_fmt;
    logic        have_data;
    logic [2:0]  err_code;

    wav_riff_header_parser_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_data_byte        (i_data_byte),
        .i_end_of_file      (i_end_of_file),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_channel_count    (o_channel_count),
        .o_sample_rate      (o_sample_rate),
        .o_sample_bits      (o_sample_bits),
        .o_block_align      (o_block_align),
        .o_bytes_per_second (o_bytes_per_second),
        .o_data_offset      (o_data_offset),
        .o_data_length      (o_data_length)
    );

    // Clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic clear_parser();
        pos_count = 32'd0;
        stage     = wrp_pkg::STG_RIFF;
        hdr_word  = 64'd0;
        hdr_count = 3'd0;
        body_left = 32'd0;
        body_type = wrp_pkg::KIND_OTHER;
        fmt_ofs   = 5'd0;
        fmt_tag   = 16'd0;
        chan      = 16'd0;
        rate      = 32'd0;
        bits      = 16'd0;
        data_at   = 32'd0;
        data_len  = 32'd0;
        have_fmt  = 1'b0;
        have_data = 1'b0;
        err_code  = wrp_pkg::ST_OK;
    endtask

    task automatic parse_beat(input logic [7:0] b, input logic eof);
        logic [3:0]   fill;
        logic [31:0]  tag_word;
        logic [31:0]  size_word;
        logic [31:0]  align;
        t_wav_summary sum;
        pos_count = pos_count + 32'd1;
        if (err_code == wrp_pkg::ST_OK) begin
            if (stage == wrp_pkg::STG_BODY) begin
                // Gather the format fields, skip byte rate and block align
                if (body_type == wrp_pkg::KIND_FMT) begin
                    case (fmt_ofs)
                        5'd0:  fmt_tag[7:0]  = b;
                        5'd1:  fmt_tag[15:8] = b;
                        5'd2:  chan[7:0]     = b;
                        5'd3:  chan[15:8]    = b;
                        5'd4:  rate[7:0]     = b;
                        5'd5:  rate[15:8]    = b;
                        5'd6:  rate[23:16]   = b;
                        5'd7:  rate[31:24]   = b;
                        5'd14: bits[7:0]     = b;
                        5'd15: bits[15:8]    = b;
                        default: ;
                    endcase
                    if (fmt_ofs < wrp_pkg::FIDX_END) fmt_ofs = fmt_ofs + 5'd1;
                end
                body_left = body_left - 32'd1;
                if (body_left == 32'd0) stage = wrp_pkg::STG_HDR;
            end else begin
                // Shift the byte into the little-endian header word
                hdr_word[8*hdr_count +: 8] = b;
                fill      = {1'b0, hdr_count} + 4'd1;
                hdr_count = fill[2:0];
                tag_word  = hdr_word[31:0];
                size_word = hdr_word[63:32];
                case (stage)
                    wrp_pkg::STG_RIFF: begin
                        if (fill == 4'd4 && tag_word != wrp_pkg::TAG_RIFF) begin
                            err_code = wrp_pkg::ST_NOT_RIFF;
                        end else if (fill == 4'd8) begin
                            stage     = wrp_pkg::STG_WAVE;
                            hdr_count = 3'd0;
                            hdr_word  = 64'd0;
                        end
                    end
                    wrp_pkg::STG_WAVE: begin
                        if (fill == 4'd4) begin
                            if (tag_word != wrp_pkg::TAG_WAVE) err_code = wrp_pkg::ST_NOT_WAVE;
                            else stage = wrp_pkg::STG_HDR;
                            hdr_count = 3'd0;
                            hdr_word  = 64'd0;
                        end
                    end
                    default: begin
                        if (fill == 4'd8) begin
                            body_type = wrp_pkg::KIND_OTHER;
                            if (tag_word == wrp_pkg::TAG_FMT) begin
                                body_type = wrp_pkg::KIND_FMT;
                                have_fmt  = 1'b1;
                                fmt_ofs   = 5'd0;
                                fmt_tag   = 16'd0;
                                chan      = 16'd0;
                                rate      = 32'd0;
                                bits      = 16'd0;
                            end else if (tag_word == wrp_pkg::TAG_DATA) begin
                                body_type = wrp_pkg::KIND_DATA;
                                have_data = 1'b1;
                                data_at   = pos_count;
                                data_len  = size_word;
                            end
                            body_left = size_word;
                            stage     = (size_word != 32'd0) ? wrp_pkg::STG_BODY
                                                             : wrp_pkg::STG_HDR;
                            hdr_count = 3'd0;
                            hdr_word  = 64'd0;
                        end
                    end
                endcase
            end
        end

        // Form the record on the final byte, then start afresh
        if (eof) begin
            if (err_code != wrp_pkg::ST_OK) sum.status = err_code;
            else if (stage == wrp_pkg::STG_RIFF)
                sum.status = (hdr_count < 3'd4) ? wrp_pkg::ST_NOT_RIFF
                                                : wrp_pkg::ST_NOT_WAVE;
            else if (stage == wrp_pkg::STG_WAVE) sum.status = wrp_pkg::ST_NOT_WAVE;
            else if (!have_fmt || !have_data) sum.status = wrp_pkg::ST_MISSING;
            else if (fmt_tag != wrp_pkg::FMT_PCM) sum.status = wrp_pkg::ST_NOT_PCM;
            else sum.status = wrp_pkg::ST_OK;
            sum.channel_count    = 16'd0;
            sum.sample_rate      = 32'd0;
            sum.sample_bits      = 16'd0;
            sum.block_align      = 16'd0;
            sum.bytes_per_second = 32'd0;
            sum.data_offset      = 32'd0;
            sum.data_length      = 32'd0;
            if (sum.status == wrp_pkg::ST_OK) begin
                align                = ({16'd0, chan} * {16'd0, bits}) >> 3;
                sum.channel_count    = chan;
                sum.sample_rate      = rate;
                sum.sample_bits      = bits;
                sum.block_align      = align[15:0];
                sum.bytes_per_second = rate * {16'd0, align[15:0]};
                sum.data_offset      = data_at;
                sum.data_length      = data_len;
            end
            summaries.push_back(sum);
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 32));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(8000, 192000));
            default: return $urandom;
        endcase
    endfunction

    task automatic put_word(input logic [31:0] w);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[31:24]);
    endtask

    // Move the built file into the beat queue, end-of-file on its last byte
    task automatic queue_file(input logic hold);
        t_file_beat beat;
        for (int k = 0; k < file_bytes.size(); k++) begin
            beat.data = file_bytes[k];
            beat.eof  = (k == file_bytes.size() - 1);
            beat.hold = hold && (k == 0);
            file_beats.push_back(beat);
        end
        file_bytes.delete();
    endtask

    task automatic build_random_file();
        int          r;
        int          chunks;
        int          emit;
        logic        std_layout;
        logic        cut;
        logic [1:0]  kind;
        logic [31:0] size;
        logic [31:0] id;
        logic [7:0]  fmt_body[24];
        logic [15:0] w16;
        logic [31:0] w32;
        r = $urandom_range(0, 99);

        // Noise, sometimes behind a good RIFF tag
        if (r < 12) begin
            if ($urandom_range(0, 1) != 0) put_word(wrp_pkg::TAG_RIFF);
            repeat ($urandom_range(1, 14)) file_bytes.push_back(8'($urandom));
            return;
        end

        // Tags, now and then with one bit flipped
        put_word((r < 16) ? (wrp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)))
                          : wrp_pkg::TAG_RIFF);
        put_word(pick32());
        put_word((r >= 16 && r < 20) ? (wrp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)))
                                     : wrp_pkg::TAG_WAVE);

        std_layout = ($urandom_range(0, 9) < 7);
        chunks     = std_layout ? $urandom_range(2, 3) : $urandom_range(1, 4);
        for (int i = 0; i < chunks; i++) begin
            if (std_layout) begin
                kind = (i == 0) ? wrp_pkg::KIND_FMT
                     : (i == chunks - 1) ? wrp_pkg::KIND_DATA : wrp_pkg::KIND_OTHER;
            end else begin
                r    = $urandom_range(0, 9);
                kind = (r < 4) ? wrp_pkg::KIND_FMT
                     : (r < 8) ? wrp_pkg::KIND_DATA : wrp_pkg::KIND_OTHER;
            end
            cut = (i == chunks - 1) && ($urandom_range(0, 9) == 0);

            // Lay out a format body; bytes past sixteen are filler
            for (int k = 0; k < 24; k++) fmt_body[k] = 8'($urandom);
            w16 = ($urandom_range(0, 4) != 0) ? wrp_pkg::FMT_PCM : pick16();
            {fmt_body[1], fmt_body[0]} = w16;
            w16 = pick16();
            {fmt_body[3], fmt_body[2]} = w16;
            w32 = pick32();
            {fmt_body[7], fmt_body[6], fmt_body[5], fmt_body[4]} = w32;
            w16 = pick16();
            {fmt_body[15], fmt_body[14]} = w16;

            case (kind)
                wrp_pkg::KIND_FMT: begin
                    id   = wrp_pkg::TAG_FMT;
                    size = ($urandom_range(0, 3) != 0) ? 32'd16 : 32'($urandom_range(0, 24));
                end
                wrp_pkg::KIND_DATA: begin
                    id   = wrp_pkg::TAG_DATA;
                    size = 32'($urandom_range(0, 10));
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       id = wrp_pkg::TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
                        1:       id = wrp_pkg::TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
                        default: id = $urandom;
                    endcase
                    size = 32'($urandom_range(0, 10));
                end
            endcase
            // Declare a body that runs past the end of the file
            if (cut) size = $urandom | 32'h100;
            emit = cut ? $urandom_range(0, 5) : int'(size);

            put_word(id);
            put_word(size);
            for (int k = 0; k < emit; k++)
                file_bytes.push_back((kind == wrp_pkg::KIND_FMT) ? fmt_body[k]
                                                                 : 8'($urandom));
        end

        // Leave a partial chunk header at the end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 7)) file_bytes.push_back(8'($urandom));
    endtask

    // Idle length: mostly short, a few long, with calm stretches of none
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(50, 150);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the oldest pending byte at the falling edge
    // ------------------------------------------------------------------------
    int send_gap   = 0;
    int send_calm  = 0;
    int send_seen  = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (in_beats != send_seen) begin
                send_seen = in_beats;
                send_gap  = pick_idle(send_calm);
            end
            if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (file_beats.size() != 0 &&
                         !(file_beats[0].hold && summaries.size() != 0)) begin
                push          <= 1'b1;
                i_data_byte   <= file_beats[0].data;
                i_end_of_file <= file_beats[0].eof;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pop at random
    // ------------------------------------------------------------------------
    int take_gap  = 0;
    int take_calm = 0;
    int take_seen = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (out_beats != take_seen) begin
                take_seen = out_beats;
                if ($urandom_range(0, 2) == 0) take_gap = pick_idle(take_calm);
            end else if (take_gap == 0 && $urandom_range(0, 15) == 0) begin
                take_gap = pick_idle(take_calm);
            end
            if (take_gap > 0) begin
                take_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check popped records, predict from accepted bytes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_wav_summary want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                out_beats++;
                if (summaries.size() == 0) begin
                    report_error($sformatf("record with status %0d and none pending",
                                           o_status));
                end else begin
                    want = summaries.pop_front();
                    check_field("status", 32'(o_status), 32'(want.status));
                    check_field("channel_count", 32'(o_channel_count),
                                32'(want.channel_count));
                    check_field("sample_rate", o_sample_rate, want.sample_rate);
                    check_field("sample_bits", 32'(o_sample_bits),
                                32'(want.sample_bits));
                    check_field("block_align", 32'(o_block_align),
                                32'(want.block_align));
                    check_field("bytes_per_second", o_bytes_per_second,
                                want.bytes_per_second);
                    check_field("data_offset", o_data_offset, want.data_offset);
                    check_field("data_length", o_data_length, want.data_length);
                end
            end
            if (push && !full) begin
                in_beats++;
                parse_beat(i_data_byte, i_end_of_file);
                file_beats.delete(0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build stimulus, reset, drain, report
    // ------------------------------------------------------------------------
    initial begin
        int files;
        clear_parser();

        // Single-byte files at both byte extremes
        file_bytes.push_back(8'hFF);
        queue_file(1'b0);
        file_bytes.push_back(8'h00);
        queue_file(1'b0);
        // RIFF tag cut short
        file_bytes.push_back(wrp_pkg::TAG_RIFF[7:0]);
        file_bytes.push_back(wrp_pkg::TAG_RIFF[15:8]);
        file_bytes.push_back(wrp_pkg::TAG_RIFF[23:16]);
        queue_file(1'b0);
        // Bad RIFF tag, trailing bytes ignored
        put_word(wrp_pkg::TAG_RIFF ^ 32'h0100_0000);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        queue_file(1'b0);
        // Good RIFF tag alone
        put_word(wrp_pkg::TAG_RIFF);
        queue_file(1'b0);
        // Bad WAVE tag
        put_word(wrp_pkg::TAG_RIFF);
        put_word(32'hFFFF_FFFF);
        put_word(wrp_pkg::TAG_WAVE ^ 32'h8000_0000);
        queue_file(1'b0);

        // Random files; now and then hold off until all records are out
        files = 0;
        while (file_beats.size() < FILE_BYTE_TARGET) begin
            build_random_file();
            queue_file(files == 0 || $urandom_range(0, 39) == 0);
            files++;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (file_beats.size() != 0 || summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop
    initial begin
        #RUN_LIMIT;
        $display("status: fail");
        $finish;
    end

endmodule
